// ===== design/sha_bsh_pkg.sv =====
// sha_bsh_pkg: shared types, constants and round functions for the sha-256 byte hasher
// no dependencies
`timescale 1ns / 1ps
package sha_bsh_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumChain = 8;
  localparam int unsigned NumBlk  = 16;
  localparam int unsigned NumRnd  = 64;

  typedef logic [WordW-1:0] word_t;

  localparam word_t InitChain [NumChain] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam word_t RoundK [NumRnd] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic CmdAbsorb = 1'b0;
  localparam logic CmdFinish = 1'b1;

  localparam logic [7:0] PadByte = 8'h80;

  // controller to datapath
  typedef struct packed {
    logic       load_byte;   // shift byte into buffer word picked by count
    logic       count_en;    // advance bit count
    logic [7:0] byte_val;
    logic       rec_len;     // latch bit count for the length words
    logic       put_len;     // write length into words 14 and 15
    logic       rnd_start;   // copy chain into working vars
    logic       rnd_step;    // one round
    logic       chain_add;   // add working vars into chain
    logic       out_shift;   // rotate chain to present next digest word
    logic       clear;       // chain, buffer and count back to reset values
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       blk_full;    // count will hit a 512 multiple with this byte
    logic       at_448;      // count mod 512 is 448
    logic       rnd_last;
  } stat_t;

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t ssig0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

// ===== design/sha_bsh_datapath.sv =====
// sha_bsh_datapath: block buffer, bit count, message schedule window and round unit
// depends on sha_bsh_pkg
`timescale 1ns / 1ps
module sha_bsh_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sha_bsh_pkg::cmd_t  cmd_i,
  output sha_bsh_pkg::stat_t stat_o,
  output sha_bsh_pkg::word_t digest_word_o
);
  import sha_bsh_pkg::*;

  word_t       blk_q [NumBlk];
  word_t       blk_d [NumBlk];
  word_t       chain_q [NumChain];
  word_t       chain_d [NumChain];
  word_t       wv_q [NumChain];
  word_t       wv_d [NumChain];
  logic [63:0] cnt_q, cnt_d;
  logic [63:0] len_q;
  logic [5:0]  rnd_q, rnd_d;

  logic [3:0]  widx;
  logic [63:0] cnt_inc;
  word_t       t1, t2, w_new;

  assign widx    = cnt_q[8:5];
  assign cnt_inc = cnt_q + 64'd8;

  assign stat_o.blk_full = (cnt_inc[8:0] == 9'd0);
  assign stat_o.at_448   = (cnt_q[8:0] == 9'd448);
  assign stat_o.rnd_last = (rnd_q == 6'd63);

  assign digest_word_o = chain_q[0];

  // buffer doubles as the 16-word schedule window during the rounds
  assign w_new = ssig1(blk_q[14]) + blk_q[9] + ssig0(blk_q[1]) + blk_q[0];
  assign t1 = wv_q[7] + bsig1(wv_q[4]) + ((wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]))
            + RoundK[rnd_q] + blk_q[0];
  assign t2 = bsig0(wv_q[0]) + ((wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2])
            ^ (wv_q[1] & wv_q[2]));

  always_comb begin
    blk_d   = blk_q;
    chain_d = chain_q;
    wv_d    = wv_q;
    cnt_d   = cnt_q;
    rnd_d   = rnd_q;
    if (cmd_i.load_byte) begin
      blk_d[widx] = {blk_q[widx][23:0], cmd_i.byte_val};
    end
    if (cmd_i.count_en) begin
      cnt_d = cnt_inc;
    end
    if (cmd_i.put_len) begin
      blk_d[14] = len_q[63:32];
      blk_d[15] = len_q[31:0];
    end
    if (cmd_i.rnd_start) begin
      wv_d  = chain_q;
      rnd_d = '0;
    end
    if (cmd_i.rnd_step) begin
      for (int i = 0; i < NumBlk - 1; i++) begin
        blk_d[i] = blk_q[i+1];
      end
      blk_d[NumBlk-1] = w_new;
      wv_d[7] = wv_q[6];
      wv_d[6] = wv_q[5];
      wv_d[5] = wv_q[4];
      wv_d[4] = wv_q[3] + t1;
      wv_d[3] = wv_q[2];
      wv_d[2] = wv_q[1];
      wv_d[1] = wv_q[0];
      wv_d[0] = t1 + t2;
      rnd_d   = rnd_q + 6'd1;
    end
    if (cmd_i.chain_add) begin
      for (int i = 0; i < NumChain; i++) begin
        chain_d[i] = chain_q[i] + wv_q[i];
      end
    end
    if (cmd_i.out_shift) begin
      for (int i = 0; i < NumChain - 1; i++) begin
        chain_d[i] = chain_q[i+1];
      end
      chain_d[NumChain-1] = chain_q[0];
    end
    if (cmd_i.clear) begin
      chain_d = InitChain;
      for (int i = 0; i < NumBlk; i++) begin
        blk_d[i] = '0;
      end
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= InitChain;
      cnt_q   <= '0;
      rnd_q   <= '0;
      for (int i = 0; i < NumBlk; i++) begin
        blk_q[i] <= '0;
      end
    end else begin
      chain_q <= chain_d;
      cnt_q   <= cnt_d;
      rnd_q   <= rnd_d;
      blk_q   <= blk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wv_q <= wv_d;
    if (cmd_i.rec_len) begin
      len_q <= cnt_q;
    end
  end

endmodule

// ===== design/sha_bsh_ctrl.sv =====
// sha_bsh_ctrl: sequencer for absorb, padding, compression and digest output
// depends on sha_bsh_pkg
`timescale 1ns / 1ps
module sha_bsh_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command_i,
  input  logic [7:0]         message_byte_i,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               last_word_o,
  input  sha_bsh_pkg::stat_t stat_i,
  output sha_bsh_pkg::cmd_t  cmd_o
);
  import sha_bsh_pkg::*;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StPad   = 7'b0000010,
    StLen   = 7'b0000100,
    StInit  = 7'b0001000,
    StRound = 7'b0010000,
    StAdd   = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  state_e     state_q, state_d;
  logic       fin_q, fin_d;     // compression belongs to a finish
  logic       pad1_q, pad1_d;   // 0x80 not yet placed
  logic       pad_q, pad_d;     // padding in progress
  logic [2:0] oc_q, oc_d;
  logic       acc;

  assign in_stall    = (state_q != StIdle);
  assign acc         = in_valid && !in_stall;
  assign out_valid   = (state_q == StOut);
  assign last_word_o = (oc_q == 3'd7);

  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    pad1_d  = pad1_q;
    oc_d    = oc_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (acc) begin
          if (command_i == CmdAbsorb) begin
            cmd_o.load_byte = 1'b1;
            cmd_o.count_en  = 1'b1;
            cmd_o.byte_val  = message_byte_i;
            if (stat_i.blk_full) begin
              fin_d   = 1'b0;
              state_d = StInit;
            end
          end else begin
            cmd_o.rec_len = 1'b1;
            pad1_d        = 1'b1;
            state_d       = StPad;
          end
        end
      end
      StPad: begin
        // first pad byte always goes in; zeros stop at 448 mod 512
        if (pad1_q || !stat_i.at_448) begin
          cmd_o.load_byte = 1'b1;
          cmd_o.count_en  = 1'b1;
          cmd_o.byte_val  = pad1_q ? PadByte : 8'h00;
          pad1_d          = 1'b0;
          if (stat_i.blk_full) begin
            fin_d   = 1'b0;
            state_d = StInit;
          end
        end else begin
          state_d = StLen;
        end
      end
      StLen: begin
        cmd_o.put_len = 1'b1;
        fin_d         = 1'b1;
        state_d       = StInit;
      end
      StInit: begin
        cmd_o.rnd_start = 1'b1;
        state_d         = StRound;
      end
      StRound: begin
        cmd_o.rnd_step = 1'b1;
        if (stat_i.rnd_last) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        cmd_o.chain_add = 1'b1;
        oc_d            = '0;
        if (fin_q) begin
          state_d = StOut;
        end else if (pad_q) begin
          state_d = StPad;
        end else begin
          state_d = StIdle;
        end
      end
      StOut: begin
        if (!out_stall) begin
          cmd_o.out_shift = 1'b1;
          oc_d            = oc_q + 3'd1;
          if (oc_q == 3'd7) begin
            cmd_o.clear = 1'b1;
            state_d     = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    pad_d = pad_q;
    if (state_q == StIdle && acc && command_i == CmdFinish) begin
      pad_d = 1'b1;
    end else if (state_q == StLen) begin
      pad_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fin_q   <= 1'b0;
      pad1_q  <= 1'b0;
      pad_q   <= 1'b0;
      oc_q    <= '0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      pad1_q  <= pad1_d;
      pad_q   <= pad_d;
      oc_q    <= oc_d;
    end
  end

endmodule

// ===== design/sha256_byte_stream_hasher.sv =====
// sha-256 over a byte stream: an absorb beat loads one byte, and the 64th byte of a block
// starts a compression (one round per cycle in the datapath round unit); a finish beat
// adds the padding bytes and the length words and then compresses (twice when the pad
// spills into a second block), then gives 8 output beats, one per cycle unstalled;
// in_stall holds off new bytes until the block is idle again. asynchronous active-low reset loads
// the initial hash values and clears the buffer and bit count
`timescale 1ns / 1ps
module sha256_byte_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command_i,
  input  logic [7:0]  message_byte_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word_o,
  output logic        last_word_o
);
  import sha_bsh_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sha_bsh_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command_i      (command_i),
    .message_byte_i (message_byte_i),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .last_word_o    (last_word_o),
    .stat_i         (stat),
    .cmd_o          (cmd)
  );

  sha_bsh_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .digest_word_o (digest_word_o)
  );

endmodule

// ===== design/sha_bsh_checker.sv =====
// sha_bsh_checker: port-level assertions for the sha-256 byte hasher, bound to the top
// depends on sha256_byte_stream_hasher ports only
`timescale 1ns / 1ps
module sha_bsh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] digest_word_o,
  input logic        last_word_o
);

  // no new input while a digest is being delivered
  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> in_stall)
    else $error("input taken during digest output");

  // after the last beat the block is ready again
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_stall && last_word_o) |=> (!out_valid && !in_stall))
    else $error("not idle after last digest beat");

  // a non-last beat is followed by another beat
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_stall && !last_word_o) |=> out_valid)
    else $error("digest burst broken");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_stall) |=> (out_valid && $stable(digest_word_o) && $stable(last_word_o)))
    else $error("stalled beat changed");

endmodule

bind sha256_byte_stream_hasher sha_bsh_checker u_sha_bsh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .digest_word_o (digest_word_o),
  .last_word_o   (last_word_o)
);
